// ===== rtl/accumulator_machine_execute_top_macros.svh =====
// Assertion macros used by the checker file
`ifndef ACCUMULATOR_MACHINE_EXECUTE_TOP_MACROS_SVH
`define ACCUMULATOR_MACHINE_EXECUTE_TOP_MACROS_SVH
// Check an implication on the rising clock edge, off during reset
`define AME_ASSERT_IMP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a plain condition on the rising clock edge, off during reset
`define AME_ASSERT(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`endif

// ===== rtl/ame_pkg.sv =====
// Package with opcodes, status codes, output kinds and sizes of the accumulator machine
package ame_pkg;
  localparam int unsigned MemDepth  = 1024;
  localparam int unsigned CodeDepth = 1024;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned MemAw     = $clog2(MemDepth);
  localparam int unsigned PcW       = $clog2(CodeDepth);
  localparam int unsigned SizeW     = 11;

  typedef enum logic [4:0] {
    OpIn = 5'd0, OpOut = 5'd1, OpOutS = 5'd2, OpAdd = 5'd3, OpSub = 5'd4,
    OpMul = 5'd5, OpDiv = 5'd6, OpMod = 5'd7, OpLoad = 5'd8, OpStore = 5'd9,
    OpClear = 5'd10, OpEnd = 5'd11, OpLoada = 5'd12, OpLoadInd = 5'd13,
    OpStoreInd = 5'd14, OpJump = 5'd15, OpCmp = 5'd16, OpJeq = 5'd17,
    OpJne = 5'd18, OpJlt = 5'd19, OpJle = 5'd20, OpJgt = 5'd21, OpJge = 5'd22
  } opcode_e;

  typedef enum logic [1:0] {
    StOk = 2'd0, StDivZero = 2'd1, StAddr = 2'd2, StJump = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    KindNone = 2'd0, KindInt = 2'd1, KindStr = 2'd2
  } out_kind_e;
endpackage

// ===== rtl/accumulator_machine_execute_top.sv =====
// Execute unit of the accumulator machine with data memory and divider
//
// Usage: one decoded instruction enters on the in channel (opcode, operand
// kind, operand value, console value) with in_valid_i/in_ready_o. One result
// item (next pc, printed value and kind, halt flag, status) leaves on the out
// channel with out_valid_o/out_ready_i. One item is at work at a time.
// Sequence: most instructions read the synchronous data memory, then execute
// and write back, then present the result. Indirect load does a second read
// at the address register and executes again; indirect store takes the plain
// path. Divide and modulo then run a restoring one-bit-per-cycle divider.
// Clear sweeps one word per cycle over the effective size (mem_size capped
// at 1024). Multiply is registered once before the accumulator write.
// After the result handshake the unit returns to idle, and only there is the
// next item accepted.
// Reset clears accumulator, address register, compare value, pc and halt;
// data memory stays undefined until written. mem_size resets to 1024.
// A result held by a stalled receiver blocks the next item until taken.
module accumulator_machine_execute_top
  import ame_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [SizeW-1:0]            cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [4:0]                  opcode_i,
  input  logic                        operand_is_memory_i,
  input  logic signed [31:0]          operand_value_i,
  input  logic signed [31:0]          console_input_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [PcW-1:0]              next_pc_o,
  output logic [1:0]                  out_kind_o,
  output logic signed [31:0]          out_value_o,
  output logic                        halted_o,
  output logic [1:0]                  status_o
);
  localparam logic [2:0] SIdle = 3'd0, SRead = 3'd1, SExec = 3'd2, SDiv = 3'd3,
                         SClr = 3'd4, SMul = 3'd5, SOut = 3'd6;

  logic [2:0] state_q, state_d;
  logic [SizeW-1:0] size_q;
  logic [DataWidth-1:0] acc_q, ar_q, cmp_q;
  logic [PcW-1:0] pc_q;
  logic halt_q;
  opcode_e op_q;
  logic ismem_q;
  logic [31:0] opv_q, con_q;
  logic [PcW-1:0] rnext_q;
  logic [1:0] rkind_q, rstat_q;
  logic [31:0] rval_q;

  logic [DataWidth-1:0] mem_q [MemDepth];
  logic [DataWidth-1:0] rdata_q;
  logic mem_re, mem_we;
  logic [MemAw-1:0] mem_raddr, mem_waddr;
  logic [DataWidth-1:0] mem_wdata;

  logic [DataWidth-1:0] mul_q;
  logic [SizeW-1:0] clr_q;
  logic [5:0] dcnt_q;
  logic [DataWidth-1:0] dquo_q, drem_q, dden_q;
  logic dnegq_q, dnegr_q;

  logic [SizeW-1:0] eff_size;
  logic opv_ok, ar_ok, in_acc;
  logic [DataWidth-1:0] operand;

  logic exec_ok, exec_acc_we;
  logic [DataWidth-1:0] exec_acc;
  logic [PcW-1:0] rnext_d_w;
  logic [1:0] rkind_d, rstat_d;

  assign eff_size = (size_q > SizeW'(MemDepth)) ? SizeW'(MemDepth) : size_q;
  assign opv_ok = !opv_q[31] && (opv_q[30:0] < 31'(eff_size));
  assign ar_ok  = !ar_q[DataWidth-1] && (ar_q < DataWidth'(eff_size));
  assign in_acc = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == SIdle);
  assign operand = ismem_q ? rdata_q : opv_q;

  // Data memory: one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem_q[mem_raddr];
  end

  // Read address: operand address, or address register for indirect load
  always_comb begin
    mem_re = 1'b0;
    mem_raddr = opv_q[MemAw-1:0];
    if (state_q == SRead) begin
      mem_re = 1'b1;
      if (op_q == OpLoadInd) mem_raddr = ar_q[MemAw-1:0];
    end
  end

  // Divider step: shift in next dividend bit, subtract when it fits
  logic [DataWidth:0] dtrial;
  logic [DataWidth-1:0] drem_sh;
  assign drem_sh = {drem_q[DataWidth-2:0], dquo_q[DataWidth-1]};
  assign dtrial = {1'b0, drem_sh} - {1'b0, dden_q};

  // Jump target
  logic signed [PcW+33:0] jt;
  logic jtake;
  assign jt = $signed({{34{1'b0}}, pc_q}) + $signed({{PcW+2{opv_q[31]}}, opv_q});
  always_comb begin
    unique case (op_q)
      OpJump: jtake = 1'b1;
      OpJeq:  jtake = (cmp_q == '0);
      OpJne:  jtake = (cmp_q != '0);
      OpJlt:  jtake = cmp_q[DataWidth-1];
      OpJle:  jtake = cmp_q[DataWidth-1] || (cmp_q == '0);
      OpJgt:  jtake = !cmp_q[DataWidth-1] && (cmp_q != '0);
      OpJge:  jtake = !cmp_q[DataWidth-1];
      default: jtake = 1'b0;
    endcase
  end

  logic [PcW-1:0] pc_inc;
  assign pc_inc = pc_q + PcW'(1);

  logic needs_opnd;
  always_comb begin
    case (op_q) inside
      OpAdd, OpSub, OpMul, OpDiv, OpMod, OpLoad, OpLoada, OpCmp: needs_opnd = 1'b1;
      default: needs_opnd = 1'b0;
    endcase
  end

  // Control sequence
  always_comb begin
    state_d = state_q;
    mem_we = 1'b0;
    mem_waddr = opv_q[MemAw-1:0];
    mem_wdata = acc_q;
    unique case (state_q)
      SIdle: if (in_acc) state_d = SRead;
      SRead: state_d = SExec;
      SExec: begin
        state_d = SOut;
        if (!halt_q && !(needs_opnd && ismem_q && !opv_ok)) begin
          if ((op_q == OpDiv || op_q == OpMod) && operand != '0) state_d = SDiv;
          else if (op_q == OpMul) state_d = SMul;
          else if (op_q == OpClear && eff_size != '0) state_d = SClr;
          else if (op_q == OpLoadInd && ar_ok && rnext_q == '0) state_d = SRead;
          if (op_q == OpStore && opv_ok) mem_we = 1'b1;
          if (op_q == OpStoreInd && ar_ok) begin
            mem_we = 1'b1;
            mem_waddr = ar_q[MemAw-1:0];
          end
        end
      end
      SDiv: if (dcnt_q == 6'd32) state_d = SOut;
      SMul: state_d = SOut;
      SClr: begin
        mem_we = 1'b1;
        mem_waddr = clr_q[MemAw-1:0];
        mem_wdata = '0;
        if (clr_q + SizeW'(1) == eff_size) state_d = SOut;
      end
      SOut: if (out_ready_i) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      size_q <= SizeW'(1024);
      acc_q <= '0;
      ar_q <= '0;
      cmp_q <= '0;
      pc_q <= '0;
      halt_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) size_q <= cfg_wdata_i;
      if (state_q == SExec && state_d != SRead) begin
        pc_q <= rnext_d_w;
        if (exec_acc_we) acc_q <= exec_acc;
        if (op_q == OpLoada && exec_ok) ar_q <= operand;
        if (op_q == OpCmp && exec_ok) cmp_q <= acc_q - operand;
        if (op_q == OpEnd && !halt_q) halt_q <= 1'b1;
      end
      if (state_q == SMul) acc_q <= mul_q;
      if (state_q == SDiv && dcnt_q == 6'd32) begin
        if (op_q == OpDiv) acc_q <= dnegq_q ? -dquo_q : dquo_q;
        else acc_q <= dnegr_q ? -drem_q : drem_q;
      end
    end
  end

  // Execute results
  always_comb begin
    exec_ok = !halt_q;
    rstat_d = StOk;
    rkind_d = KindNone;
    exec_acc_we = 1'b0;
    exec_acc = acc_q;
    rnext_d_w = pc_inc;
    if (halt_q) rnext_d_w = pc_q;
    else if (needs_opnd && ismem_q && !opv_ok) begin
      rstat_d = StAddr;
      exec_ok = 1'b0;
    end else begin
      unique case (op_q)
        OpIn:   begin exec_acc_we = 1'b1; exec_acc = con_q; end
        OpOut:  rkind_d = KindInt;
        OpOutS: rkind_d = KindStr;
        OpAdd:  begin exec_acc_we = 1'b1; exec_acc = acc_q + operand; end
        OpSub:  begin exec_acc_we = 1'b1; exec_acc = acc_q - operand; end
        OpLoad: begin exec_acc_we = 1'b1; exec_acc = operand; end
        OpDiv, OpMod: if (operand == '0) rstat_d = StDivZero;
        OpStore: if (!opv_ok) rstat_d = StAddr;
        OpLoadInd: begin
          if (!ar_ok) rstat_d = StAddr;
          else if (rnext_q != '0) begin exec_acc_we = 1'b1; exec_acc = rdata_q; end
        end
        OpStoreInd: if (!ar_ok) rstat_d = StAddr;
        OpEnd: rnext_d_w = pc_q;
        OpJump, OpJeq, OpJne, OpJlt, OpJle, OpJgt, OpJge: begin
          if (jtake) begin
            if (jt < 0 || jt >= $signed((PcW+34)'(CodeDepth))) rstat_d = StJump;
            else rnext_d_w = jt[PcW-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Item and result registers; rnext_q doubles as the indirect-load pass mark
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q <= opcode_e'(opcode_i);
      ismem_q <= operand_is_memory_i;
      opv_q <= operand_value_i;
      con_q <= console_input_i;
      rnext_q <= '0;
    end
    if (state_q == SExec) begin
      if (state_d == SRead) rnext_q <= PcW'(1);
      else begin
        rnext_q <= rnext_d_w;
        rkind_q <= rkind_d;
        rstat_q <= rstat_d;
        rval_q <= (rkind_d == KindInt) ? acc_q : '0;
      end
    end
    if (state_q == SExec) mul_q <= acc_q * operand;
    // Divider setup and iteration on magnitudes
    if (state_q == SExec) begin
      dcnt_q <= '0;
      dquo_q <= acc_q[DataWidth-1] ? -acc_q : acc_q;
      drem_q <= '0;
      dden_q <= operand[DataWidth-1] ? -operand : operand;
      dnegq_q <= acc_q[DataWidth-1] ^ operand[DataWidth-1];
      dnegr_q <= acc_q[DataWidth-1];
    end else if (state_q == SDiv && dcnt_q != 6'd32) begin
      dcnt_q <= dcnt_q + 6'd1;
      if (!dtrial[DataWidth]) begin
        drem_q <= dtrial[DataWidth-1:0];
        dquo_q <= {dquo_q[DataWidth-2:0], 1'b1};
      end else begin
        drem_q <= drem_sh;
        dquo_q <= {dquo_q[DataWidth-2:0], 1'b0};
      end
    end
    if (state_q == SExec) clr_q <= '0;
    else if (state_q == SClr) clr_q <= clr_q + SizeW'(1);
  end

  assign out_valid_o = (state_q == SOut);
  assign next_pc_o   = rnext_q;
  assign out_kind_o  = rkind_q;
  assign out_value_o = rval_q;
  assign halted_o    = halt_q;
  assign status_o    = rstat_q;
endmodule

// ===== rtl/ame_checker.sv =====
// Port-level checker for the accumulator machine execute unit, with its bind
`include "accumulator_machine_execute_top_macros.svh"
module ame_checker
  import ame_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic halted_o,
  input logic [1:0] out_kind_o
);
  `AME_ASSERT(no_in_while_out, clk_i, rst_ni, !(in_ready_o && out_valid_o), "overlap")
  `AME_ASSERT_IMP(out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o, "drop")
  `AME_ASSERT_IMP(no_out_next, clk_i, rst_ni, in_valid_i && in_ready_o |=> !out_valid_o, "early")
  `AME_ASSERT_IMP(halt_sticky, clk_i, rst_ni, halted_o |=> halted_o, "unhalt")
  `AME_ASSERT(kind_ok, clk_i, rst_ni, !out_valid_o || out_kind_o != 2'd3, "kind")
endmodule

bind accumulator_machine_execute_top ame_checker u_ame_checker (.*);
